// ===== rtl/gbw_pkg.sv =====
// Shared types and constants for the 5x5 Gaussian blur window block.
// Used by gbw_front, gbw_back, gbw_outq and gaussian_blur_window_5x5_top.
// No dependencies.
package gbw_pkg;

	localparam int WIN = 5;
	localparam int CELLS = WIN * WIN;
	localparam int ROW_W = 3;
	localparam logic [ROW_W-1:0] LAST_ROW = 3'd4;

	// floor(s / 3) for s <= 765 as (s * 683) >> 11
	localparam int GREY_SHIFT = 11;
	localparam logic [9:0] GREY_RECIP = 10'd683;

	// floor(x / 273) for x <= 69615 as (x * 122911) >> 25
	localparam int SUM_W = 17;
	localparam int ROWSUM_W = 15;
	localparam int DIV_SHIFT = 25;
	localparam logic [SUM_W-1:0] DIV_RECIP = 17'd122911;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW = 2;
	localparam int MQ_CW = 3;

	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW = 3;
	localparam int OQ_LW = 4;

	localparam logic [5:0] KERNEL [CELLS] = '{
		6'd1, 6'd4,  6'd7,  6'd4,  6'd1,
		6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
		6'd7, 6'd26, 6'd41, 6'd26, 6'd7,
		6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
		6'd1, 6'd4,  6'd7,  6'd4,  6'd1
	};

	typedef struct packed {
		logic [7:0]       grey;
		logic [ROW_W-1:0] row;
	} mid_word_t;

endpackage

// ===== rtl/gbw_front.sv =====
// Front end: grey conversion, row tagging and the word queue to the back end.
// Depends on gbw_pkg.
module gbw_front import gbw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       mid_empty,
	output mid_word_t  mid_word,
	input  logic       mid_pop
);

	logic [9:0]       sum3;
	logic [19:0]      grey_prod;
	logic             accept;
	logic [ROW_W-1:0] row_q;
	mid_word_t        word_s1;
	logic             vld_s1;
	mid_word_t        mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wr_ptr_q;
	logic [MQ_AW-1:0] rd_ptr_q;
	logic [MQ_CW-1:0] count_q;
	logic [MQ_CW-1:0] fill;

	assign sum3      = {2'b00, red} + {2'b00, green} + {2'b00, blue};
	assign grey_prod = {10'd0, sum3} * {10'd0, GREY_RECIP};
	assign fill      = count_q + {{(MQ_CW-1){1'b0}}, vld_s1};
	assign full      = (fill >= MQ_CW'(MQ_DEPTH));
	assign accept    = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				// wrap after the bottom row
				row_q <= (row_q >= LAST_ROW) ? '0 : row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.grey <= grey_prod[GREY_SHIFT +: 8];
			word_s1.row  <= row_q;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem_q[wr_ptr_q] <= word_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (vld_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (mid_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{(MQ_CW-1){1'b0}}, vld_s1}
				- {{(MQ_CW-1){1'b0}}, mid_pop};
		end
	end

	assign mid_empty = (count_q == '0);
	assign mid_word  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/gbw_back.sv =====
// Back end: 5x5 grey window, weighted sum pipeline and divide by 273.
// Depends on gbw_pkg.
module gbw_back import gbw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mid_empty,
	input  mid_word_t        mid_word,
	output logic             mid_pop,
	input  logic [OQ_LW-1:0] oq_level,
	output logic             res_vld,
	output logic [7:0]       res_data
);

	logic [7:0]          win_q [WIN][WIN];
	logic                fire_q;
	logic                vld_s1;
	logic                vld_s2;
	logic                vld_s3;
	logic [ROWSUM_W-1:0] rowsum_s1 [WIN];
	logic [SUM_W-1:0]    total_s2;
	logic [2*SUM_W-1:0]  prod_s3;
	logic [ROWSUM_W-1:0] rowsum [WIN];
	logic [SUM_W-1:0]    total;
	logic [2:0]          inflight;
	logic [OQ_LW:0]      committed;
	logic                last;

	assign inflight  = {2'b00, fire_q} + {2'b00, vld_s1} + {2'b00, vld_s2} + {2'b00, vld_s3};
	assign committed = {1'b0, oq_level} + {{(OQ_LW-2){1'b0}}, inflight};
	// hold words until the output queue has room for every result in flight
	assign mid_pop   = ~mid_empty & (committed < (OQ_LW+1)'(OQ_DEPTH));
	assign last      = (mid_word.row >= LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN; r++) begin
				for (int c = 0; c < WIN; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (mid_pop) begin
			for (int r = 0; r < WIN; r++) begin
				if ((ROW_W'(r) == mid_word.row) || (r == WIN-1 && last)) begin
					for (int c = 0; c < WIN-1; c++) begin
						win_q[r][c] <= win_q[r][c+1];
					end
					win_q[r][WIN-1] <= mid_word.grey;
				end
			end
		end
	end

	always_comb begin
		logic [SUM_W-1:0] acc;
		for (int r = 0; r < WIN; r++) begin
			acc = '0;
			for (int c = 0; c < WIN; c++) begin
				acc = acc + SUM_W'(win_q[r][c]) * SUM_W'(KERNEL[r*WIN+c]);
			end
			rowsum[r] = acc[ROWSUM_W-1:0];
		end
	end

	always_comb begin
		total = '0;
		for (int r = 0; r < WIN; r++) begin
			total = total + {{(SUM_W-ROWSUM_W){1'b0}}, rowsum_s1[r]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			fire_q <= mid_pop & last;
			vld_s1 <= fire_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rowsum_s1 <= rowsum;
		total_s2  <= total;
		prod_s3   <= {{SUM_W{1'b0}}, total_s2} * {{SUM_W{1'b0}}, DIV_RECIP};
	end

	assign res_vld  = vld_s3;
	assign res_data = prod_s3[DIV_SHIFT +: 8];

endmodule

// ===== rtl/gbw_outq.sv =====
// Result queue toward the consumer; reports its level for flow control.
// Depends on gbw_pkg.
module gbw_outq import gbw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_vld,
	input  logic [7:0]       res_data,
	output logic [OQ_LW-1:0] oq_level,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       blurred
);

	logic [7:0]       mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_LW-1:0] count_q;
	logic             take;

	assign empty    = (count_q == '0);
	assign take     = pop & ~empty;
	assign oq_level = count_q;
	assign blurred  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_vld) begin
			mem_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_vld) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {{(OQ_LW-1){1'b0}}, res_vld}
				- {{(OQ_LW-1){1'b0}}, take};
		end
	end

endmodule

// ===== rtl/gaussian_blur_window_5x5_top.sv =====
// Top level of the 5x5 Gaussian blur window block.
// Depends on gbw_pkg, gbw_front, gbw_back, gbw_outq.
//
//   channel   direction  handshake      word
//   pixel     in         push / full    red, green, blue (8 bits each)
//   result    out        pop / empty    blurred (8 bits)
//
// One pixel is taken every cycle while the word queue between front and back
// has room; every fifth pixel yields one result, passing through the grey stage,
// queue, window update, row sums, total and divide by 273 multiply.
// Reset clears the window to zeros, the row position and both queues.
// A stalled consumer fills the 8-entry result queue; the back end then holds
// words in the 4-entry queue and the front raises full.
module gaussian_blur_window_5x5_top import gbw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] blurred
);

	logic             mid_empty;
	mid_word_t        mid_word;
	logic             mid_pop;
	logic [OQ_LW-1:0] oq_level;
	logic             res_vld;
	logic [7:0]       res_data;

	gbw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.mid_empty (mid_empty),
		.mid_word  (mid_word),
		.mid_pop   (mid_pop)
	);

	gbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_word  (mid_word),
		.mid_pop   (mid_pop),
		.oq_level  (oq_level),
		.res_vld   (res_vld),
		.res_data  (res_data)
	);

	gbw_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_vld  (res_vld),
		.res_data (res_data),
		.oq_level (oq_level),
		.empty    (empty),
		.pop      (pop),
		.blurred  (blurred)
	);

endmodule

// ===== verif/gaussian_blur_window_5x5_top_tb.sv =====
// Self-checking testbench for gaussian_blur_window_5x5_top: pixel words go in,
// blurred words are predicted by a local window model and checked in order.
// Depends on gbw_pkg and the RTL of gaussian_blur_window_5x5_top.
`timescale 1ns / 1ps

module gaussian_blur_window_5x5_top_tb;
	import gbw_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_GROUPS = 310;
	localparam int QUIET_GROUPS = 60;

	localparam int unsigned GAUSS_W [25] = '{
		1, 4, 7, 4, 1,
		4, 16, 26, 16, 4,
		7, 26, 41, 26, 7,
		4, 16, 26, 16, 4,
		1, 4, 7, 4, 1
	};

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       empty;
	logic       pop;
	logic [7:0] blurred;

	// window model
	bit [7:0] grey_win [25];
	bit [2:0] win_row;
	bit [7:0] blurred_q [$];

	int err_count;
	bit src_idle_en;
	bit sink_idle_en;
	int sink_hold;
	int sink_stall;

	gaussian_blur_window_5x5_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.empty   (empty),
		.pop     (pop),
		.blurred (blurred)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// Shift the pixel into its row; after the bottom row, queue the kernel sum / 273.
	task automatic blur_predict(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
		bit [9:0] rgb_sum;
		int unsigned base;
		int unsigned weighted;
		rgb_sum = r + g + b;
		base = ((win_row >= LAST_ROW) ? LAST_ROW : win_row) * 5;
		for (int c = 0; c < 4; c++)
			grey_win[base + c] = grey_win[base + c + 1];
		grey_win[base + 4] = 8'(rgb_sum / 3);
		if (win_row < LAST_ROW) begin
			win_row = 3'(win_row + 1);
		end else begin
			win_row = '0;
			weighted = 0;
			for (int i = 0; i < 25; i++)
				weighted += grey_win[i] * GAUSS_W[i];
			blurred_q.push_back(8'(weighted / 273));
		end
	endtask

	task automatic send_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
		int gap;
		@(negedge clk);
		push <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		blur_predict(r, g, b);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
	endtask

	// Hold the sender until every expected word has come out.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (blurred_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One window column of five pixels, shaped by a random pattern.
	task automatic send_group();
		int mode;
		bit [7:0] lvl;
		bit [7:0] r;
		bit [7:0] g;
		bit [7:0] b;
		mode = $urandom_range(0, 5);
		lvl = 8'($urandom_range(0, 255));
		for (int k = 0; k < 5; k++) begin
			case (mode)
				0, 1: begin
					r = 8'($urandom_range(0, 255));
					g = 8'($urandom_range(0, 255));
					b = 8'($urandom_range(0, 255));
				end
				2: begin
					r = lvl;
					g = lvl;
					b = lvl;
				end
				3: begin
					r = lvl + 8'(k * 13);
					g = lvl + 8'(k * 7);
					b = lvl - 8'(k * 11);
				end
				4: begin
					r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				end
				default: begin
					// blue just below a multiple of three
					r = 8'($urandom_range(0, 255));
					g = 8'($urandom_range(0, 255));
					b = 8'($urandom_range(0, 85) * 3 + 2);
				end
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Partial windows after reset, saturation, grey truncation, return to black.
	task automatic test_directed();
		repeat (10) send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h01, 8'h01, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFE);
		send_pixel(8'h02, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hAA, 8'h55);
		repeat (10) send_pixel(8'h00, 8'h00, 8'h00);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		sink_hold = 200;
		for (int k = 0; k < 12; k++)
			send_group();
		wait_drained();
	endtask

	task automatic test_sender_pause();
		for (int k = 0; k < 6; k++)
			send_group();
		wait_drained();
		for (int k = 0; k < 6; k++)
			send_group();
		wait_drained();
	endtask

	task automatic test_random_stream();
		for (int n = 0; n < RANDOM_GROUPS; n++) begin
			// stretches with and without idling, chosen at random
			if (n % 20 == 0) begin
				src_idle_en = $urandom_range(0, 3) != 0;
				sink_idle_en = $urandom_range(0, 3) != 0;
			end
			if (n == RANDOM_GROUPS - QUIET_GROUPS) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end
			send_group();
		end
		wait_drained();
	endtask

	// Receiver: long hold when asked, else random stall bursts.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				pop <= 1'b0;
				sink_hold--;
			end else if (sink_stall > 0) begin
				pop <= 1'b0;
				sink_stall--;
			end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
				pop <= 1'b0;
				sink_stall = $urandom_range(0, 4);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (blurred_q.size() == 0) begin
				$display("%0t: unexpected blurred word, expected none, got %0d", $time, blurred);
				err_count++;
			end else begin
				if (blurred !== blurred_q[0]) begin
					$display("%0t: blurred mismatch, expected %0d, got %0d",
						$time, blurred_q[0], blurred);
					err_count++;
				end
				void'(blurred_q.pop_front());
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		err_count = 0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		sink_hold = 0;
		sink_stall = 0;
		win_row = '0;
		foreach (grey_win[i])
			grey_win[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_output_backpressure();
		test_sender_pause();
		test_random_stream();

		if (blurred_q.size() != 0) begin
			$display("%0t: %0d blurred words never arrived, expected %0d, got none",
				$time, blurred_q.size(), blurred_q[0]);
			err_count++;
		end
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gbw_pkg.sv
rtl/gbw_front.sv
rtl/gbw_back.sv
rtl/gbw_outq.sv
rtl/gaussian_blur_window_5x5_top.sv
verif/gaussian_blur_window_5x5_top_tb.sv
